// File: design/dpw_pkg.sv
// shared types and register codes for the depth pixel to world point block
package dpw_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X_HALF = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y_HALF = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_X       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_Y       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_Z       = 4'd7;

	// register reset values
	localparam logic [12:0] RST_PRINCIPAL_X_HALF = 13'd651;
	localparam logic [12:0] RST_PRINCIPAL_Y_HALF = 13'd507;
	localparam logic [23:0] RST_INV_FOCAL_X      = 24'd32388;
	localparam logic [23:0] RST_INV_FOCAL_Y      = 24'd32326;
	localparam logic [23:0] RST_INV_DEPTH_SCALE  = 24'd16777;
	localparam logic [63:0] RST_POSE_ROW_X       = 64'h4000_0000_0000_0000;
	localparam logic [63:0] RST_POSE_ROW_Y       = 64'h0000_4000_0000_0000;
	localparam logic [63:0] RST_POSE_ROW_Z       = 64'h0000_0000_4000_0000;

	// camera-frame point width (Q.16 metres, signed)
	localparam int unsigned CAM_W = 47;

	// live configuration seen by the datapath
	typedef struct packed {
		logic [12:0] principal_x_half;
		logic [12:0] principal_y_half;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [23:0] inv_depth_scale;
		logic [63:0] pose_row_x;
		logic [63:0] pose_row_y;
		logic [63:0] pose_row_z;
	} cfg_t;

	// camera point word between back-projection and pose transform
	typedef struct packed {
		logic signed [CAM_W-1:0] cx;
		logic signed [CAM_W-1:0] cy;
		logic [31:0] z16;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} cam_pt_t;

	// world point word at the output
	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} world_pt_t;

endpackage

// File: design/dpw_cfg.sv
// configuration register file for the depth pixel to world point block
module dpw_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	output dpw_pkg::cfg_t cfg
);

	dpw_pkg::cfg_t cfg_q;

	// writes are always accepted
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// register decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.principal_x_half <= dpw_pkg::RST_PRINCIPAL_X_HALF;
			cfg_q.principal_y_half <= dpw_pkg::RST_PRINCIPAL_Y_HALF;
			cfg_q.inv_focal_x      <= dpw_pkg::RST_INV_FOCAL_X;
			cfg_q.inv_focal_y      <= dpw_pkg::RST_INV_FOCAL_Y;
			cfg_q.inv_depth_scale  <= dpw_pkg::RST_INV_DEPTH_SCALE;
			cfg_q.pose_row_x       <= dpw_pkg::RST_POSE_ROW_X;
			cfg_q.pose_row_y       <= dpw_pkg::RST_POSE_ROW_Y;
			cfg_q.pose_row_z       <= dpw_pkg::RST_POSE_ROW_Z;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpw_pkg::REG_PRINCIPAL_X_HALF: cfg_q.principal_x_half <= cfg_data[12:0];
				dpw_pkg::REG_PRINCIPAL_Y_HALF: cfg_q.principal_y_half <= cfg_data[12:0];
				dpw_pkg::REG_INV_FOCAL_X:      cfg_q.inv_focal_x <= cfg_data[23:0];
				dpw_pkg::REG_INV_FOCAL_Y:      cfg_q.inv_focal_y <= cfg_data[23:0];
				dpw_pkg::REG_INV_DEPTH_SCALE:  cfg_q.inv_depth_scale <= cfg_data[23:0];
				dpw_pkg::REG_POSE_ROW_X:       cfg_q.pose_row_x <= cfg_data;
				dpw_pkg::REG_POSE_ROW_Y:       cfg_q.pose_row_y <= cfg_data;
				dpw_pkg::REG_POSE_ROW_Z:       cfg_q.pose_row_z <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/dpw_cam.sv
// back-projection pipeline: depth scaling and pinhole intrinsics, stages 1 to 4
module dpw_cam (
	input  logic clk,
	input  logic arst_n,
	input  dpw_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] depth_raw,
	input  logic [11:0] col,
	input  logic [11:0] row,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic out_valid,
	input  logic out_ready,
	output dpw_pkg::cam_pt_t out_pt
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [39:0] prod_z_s1;
	logic signed [38:0] prod_x_s1, prod_y_s1;
	logic [7:0] blue_s1, green_s1, red_s1;

	logic [31:0] z16_s2;
	logic signed [29:0] rx_s2, ry_s2;
	logic [7:0] blue_s2, green_s2, red_s2;

	logic [31:0] z16_s3;
	logic signed [62:0] px_s3, py_s3;
	logic [7:0] blue_s3, green_s3, red_s3;

	dpw_pkg::cam_pt_t pt_s4;

	logic signed [13:0] du, dv;
	logic [39:0] z_sum;
	logic signed [38:0] x_sum, y_sum;
	logic signed [62:0] px_sum, py_sum;

	// a stage moves when it is empty or its successor moves
	assign rdy_s4 = !v_s4 || out_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s4;
	assign out_pt = pt_s4;

	// pixel offsets from the principal point in half-pixels
	assign du = $signed({1'b0, col, 1'b0}) - $signed({1'b0, cfg.principal_x_half});
	assign dv = $signed({1'b0, row, 1'b0}) - $signed({1'b0, cfg.principal_y_half});

	// rounding adds
	assign z_sum  = prod_z_s1 + 40'd128;
	assign x_sum  = prod_x_s1 + 39'sd256;
	assign y_sum  = prod_y_s1 + 39'sd256;
	assign px_sum = px_s3 + 63'sd32768;
	assign py_sum = py_s3 + 63'sd32768;

	// valid bits, a zero depth drops out here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid && (depth_raw != 16'd0);
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: depth and ray products
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			prod_z_s1 <= depth_raw * cfg.inv_depth_scale;
			prod_x_s1 <= du * $signed({1'b0, cfg.inv_focal_x});
			prod_y_s1 <= dv * $signed({1'b0, cfg.inv_focal_y});
			blue_s1 <= blue;
			green_s1 <= green;
			red_s1 <= red;
		end
	end

	// stage 2: round to Q.16
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			z16_s2 <= z_sum[39:8];
			rx_s2 <= x_sum[38:9];
			ry_s2 <= y_sum[38:9];
			blue_s2 <= blue_s1;
			green_s2 <= green_s1;
			red_s2 <= red_s1;
		end
	end

	// stage 3: ray times depth
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			px_s3 <= rx_s2 * $signed({1'b0, z16_s2});
			py_s3 <= ry_s2 * $signed({1'b0, z16_s2});
			z16_s3 <= z16_s2;
			blue_s3 <= blue_s2;
			green_s3 <= green_s2;
			red_s3 <= red_s2;
		end
	end

	// stage 4: round camera point to Q.16 metres
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			pt_s4.cx <= px_sum[62:16];
			pt_s4.cy <= py_sum[62:16];
			pt_s4.z16 <= z16_s3;
			pt_s4.blue <= blue_s3;
			pt_s4.green <= green_s3;
			pt_s4.red <= red_s3;
		end
	end

endmodule

// File: design/dpw_pose.sv
// rigid pose pipeline: rotation, translation and saturation, stages 5 to 7
module dpw_pose (
	input  logic clk,
	input  logic arst_n,
	input  dpw_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  dpw_pkg::cam_pt_t in_pt,
	output logic out_valid,
	input  logic out_ready,
	output dpw_pkg::world_pt_t out_pt
);

	logic v_s5, v_s6, v_s7;
	logic rdy_s5, rdy_s6, rdy_s7;

	logic [63:0] pose [3];

	logic signed [62:0] m0_s5 [3];
	logic signed [62:0] m1_s5 [3];
	logic signed [48:0] m2_s5 [3];
	logic signed [15:0] t_s5 [3];
	logic [7:0] blue_s5, green_s5, red_s5;

	logic signed [63:0] acc_s6 [3];
	logic [7:0] blue_s6, green_s6, red_s6;

	logic signed [31:0] w_s7 [3];
	logic [7:0] blue_s7, green_s7, red_s7;

	logic [49:0] sh [3];

	assign pose[0] = cfg.pose_row_x;
	assign pose[1] = cfg.pose_row_y;
	assign pose[2] = cfg.pose_row_z;

	// a stage moves when it is empty or its successor moves
	assign rdy_s7 = !v_s7 || out_ready;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;
	assign out_valid = v_s7;

	assign out_pt.world_x = w_s7[0];
	assign out_pt.world_y = w_s7[1];
	assign out_pt.world_z = w_s7[2];
	assign out_pt.blue = blue_s7;
	assign out_pt.green = green_s7;
	assign out_pt.red = red_s7;

	// Q.30 accumulator back to Q.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = acc_s6[i][63:14];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// stage 5: rotation products per output row
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			for (int i = 0; i < 3; i++) begin
				m0_s5[i] <= $signed(pose[i][63:48]) * in_pt.cx;
				m1_s5[i] <= $signed(pose[i][47:32]) * in_pt.cy;
				m2_s5[i] <= $signed(pose[i][31:16]) * $signed({1'b0, in_pt.z16});
				t_s5[i] <= $signed(pose[i][15:0]);
			end
			blue_s5 <= in_pt.blue;
			green_s5 <= in_pt.green;
			red_s5 <= in_pt.red;
		end
	end

	// stage 6: sum terms, translation at Q.30, plus rounding half
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			for (int i = 0; i < 3; i++) begin
				acc_s6[i] <= 64'(m0_s5[i]) + 64'(m1_s5[i]) + 64'(m2_s5[i])
					+ $signed({{26{t_s5[i][15]}}, t_s5[i], 22'd0}) + 64'sd8192;
			end
			blue_s6 <= blue_s5;
			green_s6 <= green_s5;
			red_s6 <= red_s5;
		end
	end

	// stage 7: saturate to 32 bits
	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			for (int i = 0; i < 3; i++) begin
				if (!sh[i][49] && (|sh[i][48:31])) begin
					w_s7[i] <= 32'sh7FFF_FFFF;
				end else if (sh[i][49] && !(&sh[i][48:31])) begin
					w_s7[i] <= 32'sh8000_0000;
				end else begin
					w_s7[i] <= $signed(sh[i][31:0]);
				end
			end
			blue_s7 <= blue_s6;
			green_s7 <= green_s6;
			red_s7 <= red_s6;
		end
	end

endmodule

// File: design/depth_pixel_to_world_point.sv
// top level of the depth pixel to world point block
//
// Input channel: in_valid / in_stall with depth_raw, col, row and the three
// color bytes. A word is taken at a clock edge with in_valid high and
// in_stall low. A depth of zero is taken but gives no output word.
// Output channel: out_valid / out_stall with world_x, world_y, world_z
// (Q16.16 metres, saturated) and the color bytes passed through.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; the
// write completes in the same cycle, unknown indexes are ignored. Write
// only while no pixel is in flight.
// Path: seven register stages, stages 1 to 4 in u_cam and 5 to 7 in u_pose.
// Throughput is one word per cycle while out_stall stays low, as every
// stage then takes a new word each cycle.
// Reset clears all pipeline valid bits and loads the default intrinsics
// and identity pose. When the receiver stalls, full stages hold their
// words and bubbles close up; in_stall rises only once every stage is full.
module depth_pixel_to_world_point (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [15:0] depth_raw,
	input  logic [11:0] col,
	input  logic [11:0] row,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] world_x,
	output logic signed [31:0] world_y,
	output logic signed [31:0] world_z,
	output logic [7:0] out_blue,
	output logic [7:0] out_green,
	output logic [7:0] out_red,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	dpw_pkg::cfg_t cfg;
	dpw_pkg::cam_pt_t cam_pt;
	dpw_pkg::world_pt_t world_pt;
	logic cam_ready, cam_valid, pose_ready;

	// register file
	dpw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// back-projection into the camera frame
	dpw_cam u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (cam_ready),
		.depth_raw (depth_raw),
		.col       (col),
		.row       (row),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.out_valid (cam_valid),
		.out_ready (pose_ready),
		.out_pt    (cam_pt)
	);

	// camera frame into the world frame
	dpw_pose u_pose (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (cam_valid),
		.in_ready  (pose_ready),
		.in_pt     (cam_pt),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_pt    (world_pt)
	);

	assign in_stall = !cam_ready;

	// output word
	assign world_x = world_pt.world_x;
	assign world_y = world_pt.world_y;
	assign world_z = world_pt.world_z;
	assign out_blue = world_pt.blue;
	assign out_green = world_pt.green;
	assign out_red = world_pt.red;

endmodule
